[hw/rtl/wph_pkg.sv]
package wph_pkg;

   localparam int unsigned HEADER_BYTES = 44;
   localparam int unsigned POS_W        = 6;
   localparam int unsigned COUNT_W      = 31;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_ERROR  = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_TAG  = 3'd1;
   localparam logic [2:0] ST_NOT_PCM  = 3'd2;
   localparam logic [2:0] ST_NOT_MONO = 3'd3;
   localparam logic [2:0] ST_NOT_16   = 3'd4;

   // tags little-endian, first character in the low byte
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   // position of the last byte of each checked field
   localparam logic [POS_W-1:0] POS_RIFF   = 6'd3;
   localparam logic [POS_W-1:0] POS_WAVE   = 6'd11;
   localparam logic [POS_W-1:0] POS_FMT    = 6'd15;
   localparam logic [POS_W-1:0] POS_FORMAT = 6'd21;
   localparam logic [POS_W-1:0] POS_CHANS  = 6'd23;
   localparam logic [POS_W-1:0] POS_BITS   = 6'd35;
   localparam logic [POS_W-1:0] POS_DATA   = 6'd39;
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(HEADER_BYTES - 1);

   localparam logic [15:0] FMT_PCM      = 16'd1;
   localparam logic [15:0] CHANS_MONO   = 16'd1;
   localparam logic [15:0] BITS_PER_SMP = 16'd16;

   localparam int unsigned TDATA_W = 56;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } item_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [15:0]        sample_value;
      logic [2:0]         status_code;
      logic               final_sample;
      logic [COUNT_W-1:0] sample_count;
   } result_type;

endpackage

[hw/rtl/wph_in_reg.sv]
module wph_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  wph_pkg::item_type req_item,
   input  logic              step,
   output logic              item_valid,
   output wph_pkg::item_type item
);
   import wph_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_tready = !valid_ff || step;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hw/rtl/wph_core.sv]
module wph_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [wph_pkg::COUNT_W-1:0]  csr_wr_data,
   input  logic                         step,
   input  wph_pkg::item_type            item,
   output logic                         res_valid,
   output wph_pkg::result_type          res
);
   import wph_pkg::*;

   logic [COUNT_W-1:0] max_ff, max_in;
   logic [1:0]         phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [31:0]        acc_ff, acc_in;
   logic [7:0]         hold_ff, hold_in;
   logic               bphase_ff, bphase_in;
   logic [COUNT_W-1:0] todo_ff, todo_in;
   logic [COUNT_W-1:0] done_ff, done_in;

   logic [1:0]         phase_v;
   logic [POS_W-1:0]   pos_v;
   logic [31:0]        acc_v, acc_new;
   logic [7:0]         hold_v;
   logic               bphase_v;
   logic [COUNT_W-1:0] todo_v, done_v;
   logic [15:0]        half;
   logic [2:0]         status;
   logic [COUNT_W-1:0] avail, todo_new, cnt;

   assign max_in = csr_wr_en ? csr_wr_data : max_ff;

   // start of file wipes the parse before the beat is used
   always_comb begin
      phase_v  = item.start_of_file ? PH_HEADER : phase_ff;
      pos_v    = item.start_of_file ? '0 : pos_ff;
      acc_v    = item.start_of_file ? '0 : acc_ff;
      hold_v   = item.start_of_file ? '0 : hold_ff;
      bphase_v = item.start_of_file ? 1'b0 : bphase_ff;
      todo_v   = item.start_of_file ? '0 : todo_ff;
      done_v   = item.start_of_file ? '0 : done_ff;
   end

   assign acc_new  = {item.data_byte, acc_v[31:8]};
   assign half     = acc_new[31:16];
   assign avail    = acc_new[31:1];
   assign todo_new = (avail > max_ff) ? max_ff : avail;
   assign cnt      = done_v + COUNT_W'(1);

   always_comb begin
      status = ST_OK;
      if (pos_v == POS_RIFF && acc_new != TAG_RIFF) begin
         status = ST_BAD_TAG;
      end else if (pos_v == POS_WAVE && acc_new != TAG_WAVE) begin
         status = ST_BAD_TAG;
      end else if (pos_v == POS_FMT && acc_new != TAG_FMT) begin
         status = ST_BAD_TAG;
      end else if (pos_v == POS_FORMAT && half != FMT_PCM) begin
         status = ST_NOT_PCM;
      end else if (pos_v == POS_CHANS && half != CHANS_MONO) begin
         status = ST_NOT_MONO;
      end else if (pos_v == POS_BITS && half != BITS_PER_SMP) begin
         status = ST_NOT_16;
      end else if (pos_v == POS_DATA && acc_new != TAG_DATA) begin
         status = ST_BAD_TAG;
      end
   end

   always_comb begin
      phase_in  = phase_v;
      pos_in    = pos_v;
      acc_in    = acc_v;
      hold_in   = hold_v;
      bphase_in = bphase_v;
      todo_in   = todo_v;
      done_in   = done_v;
      res_valid = 1'b0;
      res       = '0;
      case (phase_v)
         PH_HEADER: begin
            acc_in = acc_new;
            pos_in = pos_v + POS_W'(1);
            if (status != ST_OK) begin
               phase_in         = PH_IDLE;
               res_valid        = 1'b1;
               res.result_kind  = KIND_ERROR;
               res.status_code  = status;
            end else if (pos_v == POS_LAST) begin
               todo_in   = todo_new;
               done_in   = '0;
               bphase_in = 1'b0;
               if (todo_new == '0) begin
                  phase_in        = PH_IDLE;
                  res_valid       = 1'b1;
                  res.result_kind = KIND_DONE;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            if (!bphase_v) begin
               hold_in   = item.data_byte;
               bphase_in = 1'b1;
            end else begin
               bphase_in        = 1'b0;
               done_in          = cnt;
               res_valid        = 1'b1;
               res.result_kind  = KIND_SAMPLE;
               res.sample_value = {item.data_byte, hold_v};
               res.sample_count = cnt;
               res.final_sample = (cnt >= todo_v);
               if (cnt >= todo_v) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= '1;
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         acc_ff    <= '0;
         hold_ff   <= '0;
         bphase_ff <= 1'b0;
         todo_ff   <= '0;
         done_ff   <= '0;
      end else begin
         max_ff <= max_in;
         if (step) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            acc_ff    <= acc_in;
            hold_ff   <= hold_in;
            bphase_ff <= bphase_in;
            todo_ff   <= todo_in;
            done_ff   <= done_in;
         end
      end
   end

endmodule

[hw/rtl/wph_out_reg.sv]
module wph_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                res_valid,
   input  wph_pkg::result_type res,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output wph_pkg::result_type rsp_res
);
   import wph_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (step) begin
         valid_in = res_valid;
         res_in   = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_res    = res_ff;

endmodule

[hw/rtl/wav_pcm16_header_parser_top.sv]
// WAV PCM16 mono parser. Takes one file byte per beat (tuser marks the first
// byte of a file) and checks the 44-byte header, then turns the data chunk into
// signed 16-bit samples, at most csr max_samples per file; the last one has
// tlast set and carries the total count. A failing header field gives one error
// beat; an empty data chunk or a zero max_samples gives one done beat. One byte
// is taken every cycle while rsp_tready stays high; a byte passes an input
// register and then a result register before its result is offered. req_tready
// follows rsp_tready only when both registers are full. max_samples is sampled
// when the data size field completes.
module wav_pcm16_header_parser_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [wph_pkg::COUNT_W-1:0] csr_wr_data,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,  // data_byte
   input  logic                        req_tuser,  // start_of_file
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // sample_value[15:0], status_code[18:16], sample_count[49:19], zeros above
   output logic [wph_pkg::TDATA_W-1:0] rsp_tdata,
   output logic [1:0]                  rsp_tuser,  // result_kind
   output logic                        rsp_tlast   // final_sample
);
   import wph_pkg::*;

   item_type   req_item, item;
   result_type res, rsp_res;
   logic       item_valid, res_valid, can_load, step;

   assign req_item.data_byte     = req_tdata;
   assign req_item.start_of_file = req_tuser;
   assign step                   = item_valid && can_load;

   wph_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .step       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   wph_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step),
      .item        (item),
      .res_valid   (res_valid),
      .res         (res)
   );

   wph_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .res_valid  (res_valid),
      .res        (res),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = {6'd0, rsp_res.sample_count, rsp_res.status_code, rsp_res.sample_value};
   assign rsp_tuser = rsp_res.result_kind;
   assign rsp_tlast = rsp_res.final_sample;

endmodule

[dv/tb_wav_pcm16_header_parser_top.sv]
`timescale 1ns / 1ps

module tb_wav_pcm16_header_parser_top;
   import wph_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BEATS   = 350;
   localparam int DRAIN_CYCLES   = 4;

   typedef enum logic [2:0] {
      FLT_NONE, FLT_RIFF, FLT_WAVE, FLT_FMT, FLT_FORMAT, FLT_CHANS, FLT_BITS, FLT_DATA
   } fault_type;

   typedef enum logic [1:0] {RX_FREE, RX_BUSY, RX_SLOW, RX_PULSE} rx_mode_type;

   typedef struct packed {
      logic               set_cfg;
      logic [COUNT_W-1:0] cfg_val;
      logic [5:0]         hdr_len;
      logic [31:0]        size;
      logic [7:0]         n_data;
      fault_type          fault;
      logic [7:0]         fill;
      logic               typed;
      logic [1:0]         t_kind;
      logic [2:0]         t_status;
   } file_row_type;

   localparam logic [COUNT_W-1:0] MAX_ALL = '1;

   localparam logic [7:0] EXTREME_BYTES [8] =
      '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF};

   localparam file_row_type DIRECTED [19] = '{
      '{1'b0, 31'd0,   6'd0,  32'd0,         8'd6,  FLT_NONE,   8'h00, 1'b0, KIND_SAMPLE, ST_OK},
      '{1'b0, 31'd0,   6'd44, 32'd16,        8'd16, FLT_NONE,   8'h00, 1'b0, KIND_SAMPLE, ST_OK},
      '{1'b0, 31'd0,   6'd44, 32'd8,         8'd8,  FLT_NONE,   8'hFF, 1'b0, KIND_SAMPLE, ST_OK},
      '{1'b0, 31'd0,   6'd44, 32'd8,         8'd8,  FLT_RIFF,   8'h00, 1'b1, KIND_ERROR,
        ST_BAD_TAG},
      '{1'b0, 31'd0,   6'd44, 32'd8,         8'd8,  FLT_WAVE,   8'h00, 1'b1, KIND_ERROR,
        ST_BAD_TAG},
      '{1'b0, 31'd0,   6'd44, 32'd8,         8'd8,  FLT_FMT,    8'hFF, 1'b1, KIND_ERROR,
        ST_BAD_TAG},
      '{1'b0, 31'd0,   6'd44, 32'd8,         8'd8,  FLT_FORMAT, 8'h00, 1'b1, KIND_ERROR,
        ST_NOT_PCM},
      '{1'b0, 31'd0,   6'd44, 32'd8,         8'd8,  FLT_CHANS,  8'h00, 1'b1, KIND_ERROR,
        ST_NOT_MONO},
      '{1'b0, 31'd0,   6'd44, 32'd8,         8'd8,  FLT_BITS,   8'hFF, 1'b1, KIND_ERROR,
        ST_NOT_16},
      '{1'b0, 31'd0,   6'd44, 32'd8,         8'd8,  FLT_DATA,   8'h00, 1'b1, KIND_ERROR,
        ST_BAD_TAG},
      '{1'b0, 31'd0,   6'd44, 32'd0,         8'd2,  FLT_NONE,   8'h00, 1'b1, KIND_DONE, ST_OK},
      '{1'b0, 31'd0,   6'd44, 32'd1,         8'd1,  FLT_NONE,   8'hFF, 1'b1, KIND_DONE, ST_OK},
      '{1'b1, 31'd0,   6'd44, 32'd8,         8'd8,  FLT_NONE,   8'h00, 1'b1, KIND_DONE, ST_OK},
      '{1'b1, 31'd1,   6'd44, 32'd10,        8'd10, FLT_NONE,   8'h00, 1'b0, KIND_SAMPLE, ST_OK},
      '{1'b1, 31'd3,   6'd44, 32'd7,         8'd7,  FLT_NONE,   8'hFF, 1'b0, KIND_SAMPLE, ST_OK},
      '{1'b1, MAX_ALL, 6'd44, 32'hFFFF_FFFF, 8'd9,  FLT_NONE,   8'hFF, 1'b0, KIND_SAMPLE, ST_OK},
      '{1'b0, 31'd0,   6'd20, 32'd8,         8'd0,  FLT_NONE,   8'h00, 1'b0, KIND_SAMPLE, ST_OK},
      '{1'b0, 31'd0,   6'd44, 32'd6,         8'd6,  FLT_NONE,   8'h00, 1'b0, KIND_SAMPLE, ST_OK},
      '{1'b0, 31'd0,   6'd44, 32'd4,         8'd10, FLT_NONE,   8'hFF, 1'b0, KIND_SAMPLE, ST_OK}
   };

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0]  csr_wr_data = '0;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata   = '0;
   logic                req_tuser   = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [TDATA_W-1:0]  rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                rsp_tlast;

   // parser state as predicted
   logic [1:0]          parse_state = PH_IDLE;
   logic [5:0]          hdr_pos     = '0;
   logic [31:0]         field_acc   = '0;
   logic [7:0]          low_byte    = '0;
   logic                odd_byte    = 1'b0;
   logic [COUNT_W-1:0]  quota       = '0;
   logic [COUNT_W-1:0]  delivered   = '0;
   logic [COUNT_W-1:0]  max_cfg     = MAX_ALL;

   result_type          pending_results [$];
   item_type            byte_stream [$];
   logic [7:0]          hdr_buf [HEADER_BYTES];
   result_type          want;
   int                  errors       = 0;
   int                  useful_beats = 0;
   int                  idle_cycles  = 0;
   int                  burst_left   = 0;
   logic [15:0]         rx_cycle     = '0;
   rx_mode_type         rx_mode      = RX_FREE;

   wav_pcm16_header_parser_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit parse_byte(input item_type it, output result_type res);
      logic [5:0]         pos;
      logic [2:0]         st;
      logic [COUNT_W-1:0] avail;
      logic [COUNT_W-1:0] cnt;
      res = '0;
      if (it.start_of_file) begin
         parse_state = PH_HEADER;
         hdr_pos     = '0;
         field_acc   = '0;
         low_byte    = '0;
         odd_byte    = 1'b0;
         quota       = '0;
         delivered   = '0;
      end
      case (parse_state)
         PH_HEADER: begin
            pos       = hdr_pos;
            field_acc = {it.data_byte, field_acc[31:8]};
            hdr_pos   = hdr_pos + 6'd1;
            st        = ST_OK;
            if (pos == POS_RIFF && field_acc != TAG_RIFF) st = ST_BAD_TAG;
            else if (pos == POS_WAVE && field_acc != TAG_WAVE) st = ST_BAD_TAG;
            else if (pos == POS_FMT && field_acc != TAG_FMT) st = ST_BAD_TAG;
            else if (pos == POS_FORMAT && field_acc[31:16] != FMT_PCM) st = ST_NOT_PCM;
            else if (pos == POS_CHANS && field_acc[31:16] != CHANS_MONO) st = ST_NOT_MONO;
            else if (pos == POS_BITS && field_acc[31:16] != BITS_PER_SMP) st = ST_NOT_16;
            else if (pos == POS_DATA && field_acc != TAG_DATA) st = ST_BAD_TAG;
            if (st != ST_OK) begin
               parse_state     = PH_IDLE;
               res.result_kind = KIND_ERROR;
               res.status_code = st;
               return 1'b1;
            end
            if (pos == POS_LAST) begin
               avail     = field_acc[31:1];
               quota     = (avail > max_cfg) ? max_cfg : avail;
               delivered = '0;
               odd_byte  = 1'b0;
               if (quota == '0) begin
                  parse_state     = PH_IDLE;
                  res.result_kind = KIND_DONE;
                  return 1'b1;
               end
               parse_state = PH_DATA;
            end
         end
         PH_DATA: begin
            if (!odd_byte) begin
               low_byte = it.data_byte;
               odd_byte = 1'b1;
            end else begin
               odd_byte         = 1'b0;
               cnt              = delivered + COUNT_W'(1);
               delivered        = cnt;
               res.result_kind  = KIND_SAMPLE;
               res.sample_value = {it.data_byte, low_byte};
               res.final_sample = (cnt >= quota);
               res.sample_count = cnt;
               if (res.final_sample) parse_state = PH_IDLE;
               return 1'b1;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic put_le(input int pos, input logic [31:0] val, input int nbytes);
      for (int k = 0; k < nbytes; k++) hdr_buf[pos + k] = val[8*k +: 8];
   endtask

   task automatic build_file(input logic [5:0] hdr_len, input logic [31:0] size,
                             input int n_data, input fault_type fault, input bit rnd,
                             input logic [7:0] fill);
      item_type   it;
      int         at;
      logic [7:0] flip;
      for (int k = 0; k < HEADER_BYTES; k++) hdr_buf[k] = rnd ? 8'($urandom) : fill;
      put_le(POS_RIFF - 3, TAG_RIFF, 4);
      put_le(POS_WAVE - 3, TAG_WAVE, 4);
      put_le(POS_FMT - 3, TAG_FMT, 4);
      put_le(POS_FORMAT - 1, 32'(FMT_PCM), 2);
      put_le(POS_CHANS - 1, 32'(CHANS_MONO), 2);
      put_le(POS_BITS - 1, 32'(BITS_PER_SMP), 2);
      put_le(POS_DATA - 3, TAG_DATA, 4);
      put_le(POS_LAST - 3, size, 4);
      flip = rnd ? 8'($urandom_range(1, 255)) : 8'h20;
      at   = $urandom_range(0, 3);
      case (fault)
         FLT_RIFF:   hdr_buf[POS_RIFF - at] ^= flip;
         FLT_WAVE:   hdr_buf[POS_WAVE - at] ^= flip;
         FLT_FMT:    hdr_buf[POS_FMT - at] ^= flip;
         FLT_DATA:   hdr_buf[POS_DATA - at] ^= flip;
         FLT_FORMAT: put_le(POS_FORMAT - 1, rnd ? $urandom : 32'd3, 2);
         FLT_CHANS:  put_le(POS_CHANS - 1, rnd ? $urandom : 32'd2, 2);
         FLT_BITS:   put_le(POS_BITS - 1, rnd ? $urandom : 32'd8, 2);
         default: ;
      endcase
      for (int k = 0; k < hdr_len; k++) begin
         it.data_byte     = hdr_buf[k];
         it.start_of_file = (k == 0);
         byte_stream.push_back(it);
      end
      for (int k = 0; k < n_data; k++) begin
         it.data_byte     = rnd ? 8'($urandom) : EXTREME_BYTES[k % 8];
         it.start_of_file = 1'b0;
         byte_stream.push_back(it);
      end
   endtask

   task automatic send_beat(input item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= it.data_byte;
      req_tuser  <= it.start_of_file;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_stream(input bit typed, input logic [1:0] t_kind,
                              input logic [2:0] t_status);
      result_type res;
      result_type fixed;
      fixed             = '0;
      fixed.result_kind = t_kind;
      fixed.status_code = t_status;
      foreach (byte_stream[i]) begin
         if (byte_stream[i].start_of_file || parse_state != PH_IDLE) useful_beats++;
         if (parse_byte(byte_stream[i], res)) pending_results.push_back(typed ? fixed : res);
         send_beat(byte_stream[i]);
      end
      byte_stream.delete();
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_max(input logic [COUNT_W-1:0] val);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      max_cfg = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_field(input string what, input logic [COUNT_W-1:0] exp_val,
                              input logic [COUNT_W-1:0] got_val);
      if (got_val !== exp_val) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, exp_val, got_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 16'd1;
      if (rx_cycle[7:0] == 8'd0) rx_mode <= rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_FREE:  rsp_tready <= 1'b1;
         RX_BUSY:  rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_SLOW:  rsp_tready <= ($urandom_range(0, 7) == 0);
         default:  rsp_tready <= rx_cycle[3];
      endcase
   end

   // inputs only move at the rising edge, so the falling edge sees what the next edge accepts
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, got kind %0d tdata %h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", COUNT_W'(want.result_kind), COUNT_W'(rsp_tuser));
            check_field("sample_value", COUNT_W'(want.sample_value),
                        COUNT_W'(rsp_tdata[15:0]));
            check_field("status_code", COUNT_W'(want.status_code),
                        COUNT_W'(rsp_tdata[18:16]));
            check_field("final_sample", COUNT_W'(want.final_sample), COUNT_W'(rsp_tlast));
            check_field("sample_count", want.sample_count, rsp_tdata[49:19]);
            check_field("tdata padding", '0, COUNT_W'(rsp_tdata[TDATA_W-1:50]));
         end
      end
   end

   initial begin
      file_row_type row;
      item_type     noise;
      logic [31:0]  size;
      int           n_data;
      int           pick;
      logic [5:0]   hdr_len;
      fault_type    fault;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < $size(DIRECTED); r++) begin
         row = DIRECTED[r];
         if (row.set_cfg) set_max(row.cfg_val);
         build_file(row.hdr_len, row.size, row.n_data, row.fault, 1'b0, row.fill);
         send_stream(row.typed, row.t_kind, row.t_status);
      end

      useful_beats = 0;
      while (useful_beats < RANDOM_BEATS) begin
         if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 5);
            case (pick)
               0:       set_max('0);
               1:       set_max(31'd1);
               2:       set_max(MAX_ALL);
               5:       set_max(31'($urandom));
               default: set_max(31'($urandom_range(2, 16)));
            endcase
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               noise.data_byte     = 8'($urandom);
               noise.start_of_file = 1'b0;
               byte_stream.push_back(noise);
            end
         end
         pick = $urandom_range(0, 11);
         if (pick == 0) size = $urandom;
         else if (pick == 1) size = $urandom_range(0, 1);
         else size = $urandom_range(2, 24);
         if (size > 64) n_data = $urandom_range(0, 30);
         else if ($urandom_range(0, 7) == 0) n_data = $urandom_range(0, size);
         else n_data = size + $urandom_range(0, 3);
         hdr_len = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(1, 43)) : 6'(HEADER_BYTES);
         fault = ($urandom_range(0, 5) == 0) ? fault_type'($urandom_range(1, 7)) : FLT_NONE;
         build_file(hdr_len, size, n_data, fault, 1'b1, 8'h00);
         send_stream(1'b0, KIND_SAMPLE, ST_OK);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/wph_pkg.sv
hw/rtl/wph_in_reg.sv
hw/rtl/wph_core.sv
hw/rtl/wph_out_reg.sv
hw/rtl/wav_pcm16_header_parser_top.sv
dv/tb_wav_pcm16_header_parser_top.sv
